// ===== rtl/ioro_pkg.sv =====
// Package for the in-order release reorder buffer.
// Holds widths, codes and the command type shared by the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

package ioro_pkg;

    // Field widths of the transactions.
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 64;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // The slot window; slots are indexed by the low bits of the key.
    localparam int WINDOW = 32;
    localparam int SLOT_W = $clog2(WINDOW);

    // Depth of the command queue between the front and back parts.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Action codes on the input channel.
    localparam logic [ACTION_W-1:0] ACT_ARRIVE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SKIP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FEND   = 2'd2;

    // Status codes on the output channel.
    localparam logic [STATUS_W-1:0] STAT_REL   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_STALE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd2;

    // Decoded operation carried through the queue.
    typedef enum logic [1:0] {
        OP_ARRIVE,
        OP_SKIP,
        OP_FEND,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

endpackage

// ===== rtl/ioro_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ioro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ioro_front.sv =====
// Front part: accepts input transactions, decodes the action and queues commands.
// Depends on ioro_pkg.
`timescale 1ns / 1ps

module ioro_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ioro_pkg::ACTION_W-1:0]    i_action,
    input  logic [ioro_pkg::KEY_W-1:0]       i_key,
    input  logic [ioro_pkg::HANDLE_W-1:0]    i_token_handle,
    output logic                             o_cmd_valid,
    output ioro_pkg::t_cmd                   o_cmd,
    input  logic                             i_cmd_pop
);

    ioro_pkg::t_cmd                     r_mem [ioro_pkg::FIFO_DEPTH];
    logic [ioro_pkg::FIFO_AW-1:0]       r_wp;
    logic [ioro_pkg::FIFO_AW-1:0]       r_rp;
    logic [ioro_pkg::FIFO_CW-1:0]       r_count;
    ioro_pkg::t_op                      dec_op;
    logic                               push;
    logic                               pop;

    function automatic logic [ioro_pkg::FIFO_CW-1:0] FIFO_CW_ONE(input logic b);
        FIFO_CW_ONE = {{(ioro_pkg::FIFO_CW-1){1'b0}}, b};
    endfunction

    // Classify the action; the unused code becomes a no-op.
    always_comb begin
        unique case (i_action)
            ioro_pkg::ACT_ARRIVE: dec_op = ioro_pkg::OP_ARRIVE;
            ioro_pkg::ACT_SKIP:   dec_op = ioro_pkg::OP_SKIP;
            ioro_pkg::ACT_FEND:   dec_op = ioro_pkg::OP_FEND;
            default:              dec_op = ioro_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_count == ioro_pkg::FIFO_CW'(ioro_pkg::FIFO_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{op: dec_op, key: i_key, handle: i_token_handle};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + FIFO_CW_ONE(push) - FIFO_CW_ONE(pop);
        end
    end

    // The fill count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ioro_pkg::FIFO_CW'(ioro_pkg::FIFO_DEPTH))
        else $error("command queue overfilled");

endmodule

// ===== rtl/ioro_back.sv =====
// Back part: slot store, expected key, release drain and the result register.
// Depends on ioro_pkg and ioro_ram.
`timescale 1ns / 1ps

module ioro_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ioro_pkg::KEY_W-1:0]       i_cfg_wdata,
    input  logic                             i_cmd_valid,
    input  ioro_pkg::t_cmd                   i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ioro_pkg::HANDLE_W-1:0]    o_token_handle_res,
    output logic [ioro_pkg::KEY_W-1:0]       o_token_key,
    output logic                             o_frame_end,
    output logic [ioro_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_last
);

    typedef enum logic [1:0] {S_IDLE, S_DRAIN, S_READ} t_state;

    t_state                             r_state;
    logic [ioro_pkg::KEY_W-1:0]         r_exp;
    logic [ioro_pkg::WINDOW-1:0]        r_present;
    logic [ioro_pkg::WINDOW-1:0]        r_skipped;
    logic [ioro_pkg::WINDOW-1:0]        r_fend;

    // Release held back until it is known whether another follows it.
    logic                               r_pend_valid;
    logic [ioro_pkg::HANDLE_W-1:0]      r_pend_handle;
    logic [ioro_pkg::KEY_W-1:0]         r_pend_key;
    logic                               r_pend_fe;

    logic                               r_out_valid;
    logic [ioro_pkg::HANDLE_W-1:0]      r_out_handle;
    logic [ioro_pkg::KEY_W-1:0]         r_out_key;
    logic                               r_out_fe;
    logic [ioro_pkg::STATUS_W-1:0]      r_out_status;
    logic                               r_out_last;

    logic [ioro_pkg::SLOT_W-1:0]        cmd_slot;
    logic [ioro_pkg::SLOT_W-1:0]        exp_slot;
    logic [ioro_pkg::KEY_W-1:0]         key_dist;
    logic                               below;
    logic                               in_win;
    logic                               can_emit;
    logic                               out_load;
    logic                               ram_we;
    logic                               ram_re;
    logic [ioro_pkg::HANDLE_W-1:0]      ram_rdata;

    // Classification of the queued command against the current state.
    assign cmd_slot = i_cmd.key[ioro_pkg::SLOT_W-1:0];
    assign exp_slot = r_exp[ioro_pkg::SLOT_W-1:0];
    assign key_dist = i_cmd.key - r_exp;
    assign below    = (i_cmd.key < r_exp);
    assign in_win   = (key_dist[ioro_pkg::KEY_W-1:ioro_pkg::SLOT_W] == '0);
    assign can_emit = !r_out_valid || !i_out_stall;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && can_emit && !i_cfg_we;

    // A new result enters the output register this cycle.
    assign out_load = (o_cmd_pop && (i_cmd.op != ioro_pkg::OP_NONE) &&
                       ((below && (i_cmd.op == ioro_pkg::OP_ARRIVE)) ||
                        (!below && !in_win) ||
                        (!below && in_win && (i_cmd.op == ioro_pkg::OP_ARRIVE) &&
                         r_skipped[cmd_slot])))
                   || (!i_cfg_we && (r_state == S_DRAIN) && !r_skipped[exp_slot] &&
                       !r_present[exp_slot] && r_pend_valid && can_emit)
                   || (!i_cfg_we && (r_state == S_READ) && r_pend_valid && can_emit);

    // An in-window token ahead of the expected key goes to the handle store.
    assign ram_we = o_cmd_pop && (i_cmd.op == ioro_pkg::OP_ARRIVE) && !below && in_win
                    && !r_skipped[cmd_slot] && (key_dist != '0);
    assign ram_re = (r_state == S_DRAIN) && !r_skipped[exp_slot] && r_present[exp_slot];

    ioro_ram #(
        .WIDTH (ioro_pkg::HANDLE_W),
        .DEPTH (ioro_pkg::WINDOW)
    ) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cmd_slot),
        .i_wdata (i_cmd.handle),
        .i_re    (ram_re),
        .i_raddr (exp_slot),
        .o_rdata (ram_rdata)
    );

    // Command execution, drain sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_exp        <= '0;
            r_present    <= '0;
            r_skipped    <= '0;
            r_fend       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                // Restart: new expected key and all slot marks cleared.
                r_exp     <= i_cfg_wdata;
                r_present <= '0;
                r_skipped <= '0;
                r_fend    <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (o_cmd_pop && i_cmd.op != ioro_pkg::OP_NONE) begin
                            if (below) begin
                                if (i_cmd.op == ioro_pkg::OP_ARRIVE) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_handle <= i_cmd.handle;
                                    r_out_key    <= i_cmd.key;
                                    r_out_fe     <= 1'b0;
                                    r_out_status <= ioro_pkg::STAT_STALE;
                                    r_out_last   <= 1'b1;
                                end
                            end else if (!in_win) begin
                                r_out_valid  <= 1'b1;
                                r_out_handle <= (i_cmd.op == ioro_pkg::OP_ARRIVE) ?
                                                i_cmd.handle : '0;
                                r_out_key    <= i_cmd.key;
                                r_out_fe     <= 1'b0;
                                r_out_status <= ioro_pkg::STAT_OVER;
                                r_out_last   <= 1'b1;
                            end else begin
                                case (i_cmd.op)
                                    ioro_pkg::OP_ARRIVE: begin
                                        if (r_skipped[cmd_slot]) begin
                                            r_out_valid  <= 1'b1;
                                            r_out_handle <= i_cmd.handle;
                                            r_out_key    <= i_cmd.key;
                                            r_out_fe     <= 1'b0;
                                            r_out_status <= ioro_pkg::STAT_STALE;
                                            r_out_last   <= 1'b1;
                                        end else if (key_dist == '0) begin
                                            r_pend_valid        <= 1'b1;
                                            r_pend_handle       <= i_cmd.handle;
                                            r_pend_key          <= i_cmd.key;
                                            r_pend_fe           <= r_fend[cmd_slot];
                                            r_present[cmd_slot] <= 1'b0;
                                            r_fend[cmd_slot]    <= 1'b0;
                                            r_exp               <= r_exp + 1'b1;
                                            r_state             <= S_DRAIN;
                                        end else begin
                                            r_present[cmd_slot] <= 1'b1;
                                        end
                                    end
                                    ioro_pkg::OP_SKIP: begin
                                        r_skipped[cmd_slot] <= 1'b1;
                                        r_present[cmd_slot] <= 1'b0;
                                        if (key_dist == '0) begin
                                            r_state <= S_DRAIN;
                                        end
                                    end
                                    default: begin
                                        r_fend[cmd_slot] <= 1'b1;
                                    end
                                endcase
                            end
                        end
                    end
                    S_DRAIN: begin
                        if (r_skipped[exp_slot]) begin
                            // Pass over a skipped key and drop its marks.
                            r_skipped[exp_slot] <= 1'b0;
                            r_present[exp_slot] <= 1'b0;
                            r_fend[exp_slot]    <= 1'b0;
                            r_exp               <= r_exp + 1'b1;
                        end else if (r_present[exp_slot]) begin
                            r_state <= S_READ;
                        end else if (r_pend_valid) begin
                            if (can_emit) begin
                                r_out_valid  <= 1'b1;
                                r_out_handle <= r_pend_handle;
                                r_out_key    <= r_pend_key;
                                r_out_fe     <= r_pend_fe;
                                r_out_status <= ioro_pkg::STAT_REL;
                                r_out_last   <= 1'b1;
                                r_pend_valid <= 1'b0;
                                r_state      <= S_IDLE;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_READ: begin
                        if (!r_pend_valid || can_emit) begin
                            if (r_pend_valid) begin
                                r_out_valid  <= 1'b1;
                                r_out_handle <= r_pend_handle;
                                r_out_key    <= r_pend_key;
                                r_out_fe     <= r_pend_fe;
                                r_out_status <= ioro_pkg::STAT_REL;
                                r_out_last   <= 1'b0;
                            end
                            r_pend_valid        <= 1'b1;
                            r_pend_handle       <= ram_rdata;
                            r_pend_key          <= r_exp;
                            r_pend_fe           <= r_fend[exp_slot];
                            r_present[exp_slot] <= 1'b0;
                            r_fend[exp_slot]    <= 1'b0;
                            r_exp               <= r_exp + 1'b1;
                            r_state             <= S_DRAIN;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_token_handle_res = r_out_handle;
    assign o_token_key        = r_out_key;
    assign o_frame_end        = r_out_fe;
    assign o_status           = r_out_status;
    assign o_last             = r_out_last;

    // A held-back release only exists while a drain is running.
    a_pend_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state != S_IDLE))
        else $error("held release while idle");

    // A rejected transaction is always the only and final result.
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ioro_pkg::STAT_REL) |-> r_out_last)
        else $error("rejected result not marked last");

    // Rejected results never carry a frame end.
    a_reject_no_fe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ioro_pkg::STAT_REL) |-> !r_out_fe)
        else $error("rejected result with frame end");

    // The handle store is read only for a buffered, unskipped slot.
    a_read_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> r_present[exp_slot])
        else $error("slot read without a buffered token");

endmodule

// ===== rtl/in_order_release_reorder_buffer_top.sv =====
// Top level of the in-order release reorder buffer.
// Depends on ioro_pkg, ioro_front, ioro_back (and ioro_ram through ioro_back).
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------------
//  in       | input     | i_in_valid / o_in_stall| i_action, i_key, i_token_handle
//  out      | output    | o_out_valid/i_out_stall| handle, key, frame end, status, last
//  cfg      | input     | i_cfg_we               | i_cfg_wdata (first key)
//
// A transaction that causes no drain is handled by the back part in its idle state. One
// that reaches the expected key starts a drain: a passed-over skipped key is dropped in the
// drain state, a buffered token goes through the drain state (slot look-up) and then the read
// state (handle store read); the final release waits in the drain state while output stalls.
// Reset is synchronous and clears all slot marks at once; the expected key becomes zero.
// A two-entry command queue accepts until full while the back part drains or the output stalls.
`timescale 1ns / 1ps

module in_order_release_reorder_buffer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ioro_pkg::KEY_W-1:0]       i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ioro_pkg::ACTION_W-1:0]    i_action,
    input  logic [ioro_pkg::KEY_W-1:0]       i_key,
    input  logic [ioro_pkg::HANDLE_W-1:0]    i_token_handle,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ioro_pkg::HANDLE_W-1:0]    o_token_handle_res,
    output logic [ioro_pkg::KEY_W-1:0]       o_token_key,
    output logic                             o_frame_end,
    output logic [ioro_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_last
);

    logic           cmd_valid;
    ioro_pkg::t_cmd cmd;
    logic           cmd_pop;

    ioro_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_token_handle (i_token_handle),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    ioro_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd_valid        (cmd_valid),
        .i_cmd              (cmd),
        .o_cmd_pop          (cmd_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_token_handle_res (o_token_handle_res),
        .o_token_key        (o_token_key),
        .o_frame_end        (o_frame_end),
        .o_status           (o_status),
        .o_last             (o_last)
    );

endmodule
